// File: sv/button_morse_decoder_top_assert.svh
// Assertion macros for the Morse key decoder top level.
// Expects clk and rst in the scope where the macros are used.
`ifndef BUTTON_MORSE_DECODER_TOP_ASSERT_SVH
`define BUTTON_MORSE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BMD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmd same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmd next-cycle check failed");

`endif

// File: sv/bmd_pkg.sv
// Shared types, constants and the letter table of the Morse key decoder.
// No dependencies.
package bmd_pkg;

  localparam int MAX_ELEMENTS = 4;
  localparam int CNT_W        = 8;
  localparam int ELEM_W       = 3;
  localparam int PAT_W        = 4;
  localparam int CHAR_W       = 7;

  localparam logic [CNT_W-1:0]  DASH_TICKS_RST = 8'd8;
  localparam logic [CNT_W-1:0]  GAP_TICKS_RST  = 8'd8;
  localparam logic [CNT_W-1:0]  CNT_MAX        = 8'hff;
  localparam logic [CHAR_W-1:0] CHAR_UNKNOWN   = 7'h3f;

  localparam logic ADDR_DASH_TICKS = 1'b0;
  localparam logic ADDR_GAP_TICKS  = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0]  tick_count;
    logic              in_press;
    logic              dash_seen;
    logic [ELEM_W-1:0] elements_held;
    logic [PAT_W-1:0]  pattern_held;
    logic              indicator_on;
  } bmd_state_t;

  typedef struct packed {
    logic              indicator;
    logic              letter_valid;
    logic [CHAR_W-1:0] letter;
    logic [ELEM_W-1:0] element_count;
    logic [PAT_W-1:0]  element_bits;
  } bmd_result_t;

  typedef struct packed {
    logic [CNT_W-1:0] dash_ticks;
    logic [CNT_W-1:0] gap_ticks;
  } bmd_cfg_t;

  function automatic logic [CHAR_W-1:0] morse_letter(input logic [ELEM_W-1:0] len,
                                                     input logic [PAT_W-1:0] bits);
    logic [CHAR_W-1:0] ch;
    ch = CHAR_UNKNOWN;
    unique case (len)
      3'd1: ch = bits[0] ? 7'h54 : 7'h45;
      3'd2: begin
        unique case (bits[1:0])
          2'd0: ch = 7'h49;
          2'd1: ch = 7'h4e;
          2'd2: ch = 7'h41;
          default: ch = 7'h4d;
        endcase
      end
      3'd3: begin
        unique case (bits[2:0])
          3'd0: ch = 7'h53;
          3'd1: ch = 7'h44;
          3'd2: ch = 7'h52;
          3'd3: ch = 7'h47;
          3'd4: ch = 7'h55;
          3'd5: ch = 7'h4b;
          3'd6: ch = 7'h57;
          default: ch = 7'h4f;
        endcase
      end
      3'd4: begin
        unique case (bits)
          4'd0:  ch = 7'h48;
          4'd1:  ch = 7'h42;
          4'd2:  ch = 7'h4c;
          4'd3:  ch = 7'h5a;
          4'd4:  ch = 7'h46;
          4'd5:  ch = 7'h43;
          4'd6:  ch = 7'h50;
          4'd8:  ch = 7'h56;
          4'd9:  ch = 7'h58;
          4'd11: ch = 7'h51;
          4'd13: ch = 7'h59;
          4'd14: ch = 7'h4a;
          default: ch = CHAR_UNKNOWN;
        endcase
      end
      default: ch = CHAR_UNKNOWN;
    endcase
    return ch;
  endfunction

endpackage

// File: sv/bmd_cfg.sv
// APB-style register file for the dash and gap thresholds.
// Depends on bmd_pkg.
module bmd_cfg
  import bmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output bmd_cfg_t    cfg
);

  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dash_ticks <= DASH_TICKS_RST;
      cfg.gap_ticks  <= GAP_TICKS_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        ADDR_DASH_TICKS: cfg.dash_ticks <= pwdata[CNT_W-1:0];
        ADDR_GAP_TICKS:  cfg.gap_ticks  <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ADDR_DASH_TICKS: prdata = {{(32-CNT_W){1'b0}}, cfg.dash_ticks};
      ADDR_GAP_TICKS:  prdata = {{(32-CNT_W){1'b0}}, cfg.gap_ticks};
      default:         prdata = '0;
    endcase
  end

endmodule

// File: sv/bmd_step.sv
// Next-state and result logic for one key sample.
// Depends on bmd_pkg.
module bmd_step
  import bmd_pkg::*;
(
  input  bmd_state_t  st,
  input  bmd_cfg_t    cfg,
  input  logic        pressed,
  output bmd_state_t  st_next,
  output bmd_result_t res
);

  logic             edge_seen;
  logic [CNT_W-1:0] cnt_inc;

  assign edge_seen = pressed ^ st.in_press;
  assign cnt_inc   = (st.tick_count == CNT_MAX) ? CNT_MAX : st.tick_count + 1'b1;

  always_comb begin
    st_next = st;
    res     = '0;
    st_next.in_press   = pressed;
    st_next.tick_count = edge_seen ? '0 : cnt_inc;
    if (pressed) begin
      if (edge_seen) begin
        st_next.dash_seen    = 1'b0;
        st_next.indicator_on = 1'b0;
      end
      if (st_next.tick_count >= cfg.dash_ticks) begin
        st_next.dash_seen    = 1'b1;
        st_next.indicator_on = 1'b1;
      end
    end else begin
      st_next.indicator_on = 1'b0;
      if (edge_seen && st.elements_held < ELEM_W'(MAX_ELEMENTS)) begin
        st_next.pattern_held[st.elements_held[1:0]] = st.dash_seen;
        st_next.elements_held = st.elements_held + 1'b1;
      end
      if (st_next.tick_count >= cfg.gap_ticks) begin
        if (st_next.elements_held != '0) begin
          res.letter_valid  = 1'b1;
          res.letter        = morse_letter(st_next.elements_held, st_next.pattern_held);
          res.element_count = st_next.elements_held;
          res.element_bits  = st_next.pattern_held;
        end
        st_next.elements_held = '0;
        st_next.pattern_held  = '0;
      end
    end
    res.indicator = st_next.indicator_on;
  end

endmodule

// File: sv/button_morse_decoder_top.sv
// Morse key decoder top level: input register, state update, result register.
// Depends on bmd_pkg, bmd_cfg, bmd_step and button_morse_decoder_top_assert.svh.
//
// Takes one sampled key level per clock and returns one result per sample; each
// sample passes the input register, then the result register. Throughput is one
// sample per clock while the output is not stalled, set by the combinational
// state update between the two registers; an output stall holds both stages and
// reaches the input stall in the same cycle. Thresholds are written through the
// APB port at 0x0 (dash_ticks) and 0x4 (gap_ticks), both resetting to 8.
`include "button_morse_decoder_top_assert.svh"

module button_morse_decoder_top
  import bmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              pressed,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              indicator,
  output logic              letter_valid,
  output logic [CHAR_W-1:0] letter,
  output logic [ELEM_W-1:0] element_count,
  output logic [PAT_W-1:0]  element_bits
);

  bmd_cfg_t    cfg;
  bmd_state_t  st;
  bmd_state_t  st_next;
  bmd_result_t res_next;
  bmd_result_t res;
  logic        s0_valid;
  logic        s0_pressed;
  logic        s1_load;

  bmd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bmd_step u_step (
    .st      (st),
    .cfg     (cfg),
    .pressed (s0_pressed),
    .st_next (st_next),
    .res     (res_next)
  );

  assign s1_load  = !out_valid || !out_stall;
  assign in_stall = s0_valid && !s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (!in_stall) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s0_pressed <= pressed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else if (s1_load) begin
      out_valid <= s0_valid;
      if (s0_valid) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && s0_valid) begin
      res <= res_next;
    end
  end

  assign indicator     = res.indicator;
  assign letter_valid  = res.letter_valid;
  assign letter        = res.letter;
  assign element_count = res.element_count;
  assign element_bits  = res.element_bits;

  `BMD_ASSERT_NOW(a_letter_len, out_valid && letter_valid,
                  element_count != '0 && element_count <= ELEM_W'(MAX_ELEMENTS))
  `BMD_ASSERT_NOW(a_no_letter_zero, out_valid && !letter_valid,
                  letter == '0 && element_count == '0 && element_bits == '0)
  `BMD_ASSERT_NOW(a_ind_dash, out_valid && indicator, st.dash_seen && st.in_press)
  `BMD_ASSERT_NEXT(a_stall_hold, in_stall, s0_valid && $stable(s0_pressed))

endmodule
